>>> hdl/crc32iu_pkg.sv
// Shared constants, types and CRC helper functions for the CRC32/CRC32C instruction unit.
// No dependencies; every other file of the unit refers to this package by scoped names.

package crc32iu_pkg;

  localparam logic [31:0] PolyCrc32  = 32'hedb88320;
  localparam logic [31:0] PolyCrc32c = 32'h82f63b78;

  // Register index that reads as zero and discards writes.
  localparam logic [4:0] ZeroReg = 5'd31;

  // Operation variant codes.
  localparam logic [1:0] VarCrc32  = 2'd0;
  localparam logic [1:0] VarCrc32c = 2'd1;

  // Legal access sizes in bytes, and the only legal result size.
  localparam logic [3:0] Size1       = 4'd1;
  localparam logic [3:0] Size2       = 4'd2;
  localparam logic [3:0] Size4       = 4'd4;
  localparam logic [3:0] Size8       = 4'd8;
  localparam logic [3:0] ResultBytes = 4'd4;

  // Stream payload widths.
  localparam int unsigned InDataW   = 184;
  localparam int unsigned InUserW   = 3;
  localparam int unsigned OutDataW  = 104;
  localparam int unsigned OutUserW  = 1;

  // Accumulator and data operand side by side: accumulator in the low bits.
  localparam int unsigned OperandW = 96;

  // Selects one of the eight fold matrices.
  typedef struct packed {
    logic       castagnoli;
    logic [1:0] size_log2;
  } fold_sel_t;

  // Bitwise reflected CRC over the low nbytes bytes of data.
  function automatic logic [31:0] fold_bytes(logic [31:0] acc_in, logic [63:0] data,
                                             int unsigned nbytes, logic [31:0] poly);
    logic [31:0] acc;
    begin
      acc = acc_in;
      for (int b = 0; b < 8; b++) begin
        if (b < nbytes) begin
          acc = acc ^ {24'd0, data[8*b +: 8]};
          for (int k = 0; k < 8; k++) begin
            acc = (acc >> 1) ^ (acc[0] ? poly : 32'd0);
          end
        end
      end
      return acc;
    end
  endfunction

  // Row of the fold matrix for one result bit. The fold is linear in the
  // operand bits, so each result bit is the parity of a masked operand.
  function automatic logic [OperandW-1:0] crc_mask(logic [31:0] poly, int unsigned nbytes,
                                                   logic [4:0] obit);
    logic [OperandW-1:0] m;
    logic [31:0]         r;
    logic [31:0]         a;
    logic [63:0]         d;
    begin
      m = '0;
      for (int j = 0; j < OperandW; j++) begin
        a = (j < 32) ? (32'd1 << j) : 32'd0;
        d = (j >= 32) ? (64'd1 << (j - 32)) : 64'd0;
        r = fold_bytes(a, d, nbytes, poly);
        m[j] = r[obit];
      end
      return m;
    end
  endfunction

endpackage

>>> hdl/crc32iu_fold.sv
// Combinational CRC fold: XOR trees for both polynomials and all four access sizes.
// Depends on crc32iu_pkg for the polynomials and the fold matrix rows.

module crc32iu_fold (
  input  crc32iu_pkg::fold_sel_t sel_i,
  input  logic [31:0]            acc_i,
  input  logic [63:0]            data_i,
  output logic [31:0]            crc_o
);

  logic [crc32iu_pkg::OperandW-1:0] operand;
  logic [31:0]                      parity [2][4];

  assign operand = {data_i, acc_i};

  for (genvar gv = 0; gv < 2; gv++) begin : g_poly
    for (genvar gs = 0; gs < 4; gs++) begin : g_size
      for (genvar gi = 0; gi < 32; gi++) begin : g_bit
        localparam logic [crc32iu_pkg::OperandW-1:0] Mask = crc32iu_pkg::crc_mask(
            (gv == 1) ? crc32iu_pkg::PolyCrc32c : crc32iu_pkg::PolyCrc32,
            1 << gs, 5'(gi));
        assign parity[gv][gs][gi] = ^(Mask & operand);
      end
    end
  end

  assign crc_o = parity[sel_i.castagnoli][sel_i.size_log2];

endmodule

>>> hdl/crc32_instruction_unit.sv
// Top level of the CRC32/CRC32C instruction unit: input register, decode checks, result register.
// Depends on crc32iu_pkg and crc32iu_fold.
//
//  Channel  | Direction | tdata (low bit up)                          | tuser
//  s_axis   | in        | operand/result bytes, wide, indices, values, pc | class, variant
//  m_axis   | out       | crc_result, write_enable, write_index, next_pc | status
//
// Each instruction passes through the input register and then the result register.
// One instruction is accepted every cycle unless both registers are full and the output is stalled; the
// CRC fold is a flat XOR tree between the two registers.
// Reset empties both registers. A stalled output holds its result; the input register
// keeps accepting as long as the result register drains or is empty.

module crc32_instruction_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [3:0] op_bytes, [7:4] res_bytes, [8] wide_form, [13:9] acc_reg_index,
  // [18:14] data_reg_index, [23:19] dest_reg_index, [55:24] acc_reg_value,
  // [119:56] data_reg_value, [183:120] pc_in
  input  logic [183:0] s_axis_tdata_i,
  // [0] is_two_source_class, [2:1] crc_variant
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] crc_result, [32] write_enable, [37:33] write_index, [101:38] next_pc,
  // [103:102] zero
  output logic [103:0] m_axis_tdata_o,
  // [0] status
  output logic [0:0]   m_axis_tuser_o
);

  logic                                in_valid_q;
  logic [crc32iu_pkg::InDataW-1:0]     in_data_q;
  logic [crc32iu_pkg::InUserW-1:0]     in_user_q;
  logic                                out_valid_q;
  logic [crc32iu_pkg::OutDataW-1:0]    out_data_q;
  logic [crc32iu_pkg::OutDataW-1:0]    out_data_d;
  logic                                out_status_q;
  logic                                out_status_d;

  logic        out_free;
  logic        advance;
  logic        in_take;

  logic        two_source;
  logic [1:0]  variant;
  logic [3:0]  op_bytes;
  logic [3:0]  res_bytes;
  logic        wide_form;
  logic [4:0]  acc_idx;
  logic [4:0]  data_idx;
  logic [4:0]  dest_idx;
  logic [31:0] acc_val;
  logic [63:0] data_val;
  logic [63:0] pc;

  logic        size_ok;
  logic        fields_ok;
  logic [31:0] acc_op;
  logic [63:0] data_op;
  logic [31:0] crc;
  logic        wr_en;
  crc32iu_pkg::fold_sel_t fold_sel;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata_i;
      in_user_q <= s_axis_tuser_i;
    end
  end

  assign two_source  = in_user_q[0];
  assign variant     = in_user_q[2:1];
  assign op_bytes    = in_data_q[3:0];
  assign res_bytes   = in_data_q[7:4];
  assign wide_form   = in_data_q[8];
  assign acc_idx     = in_data_q[13:9];
  assign data_idx    = in_data_q[18:14];
  assign dest_idx    = in_data_q[23:19];
  assign acc_val     = in_data_q[55:24];
  assign data_val    = in_data_q[119:56];
  assign pc          = in_data_q[183:120];

  always_comb begin
    size_ok             = 1'b1;
    fold_sel.castagnoli = (variant == crc32iu_pkg::VarCrc32c);
    fold_sel.size_log2  = 2'd0;
    unique case (op_bytes)
      crc32iu_pkg::Size1: fold_sel.size_log2 = 2'd0;
      crc32iu_pkg::Size2: fold_sel.size_log2 = 2'd1;
      crc32iu_pkg::Size4: fold_sel.size_log2 = 2'd2;
      crc32iu_pkg::Size8: fold_sel.size_log2 = 2'd3;
      default:            size_ok            = 1'b0;
    endcase
  end

  assign fields_ok = two_source
                  && (variant == crc32iu_pkg::VarCrc32 || variant == crc32iu_pkg::VarCrc32c)
                  && size_ok
                  && (res_bytes == crc32iu_pkg::ResultBytes)
                  && (wide_form == (op_bytes == crc32iu_pkg::Size8));

  assign acc_op  = (acc_idx == crc32iu_pkg::ZeroReg) ? 32'd0 : acc_val;
  assign data_op = (data_idx == crc32iu_pkg::ZeroReg) ? 64'd0 : data_val;

  crc32iu_fold u_fold (
    .sel_i  (fold_sel),
    .acc_i  (acc_op),
    .data_i (data_op),
    .crc_o  (crc)
  );

  assign wr_en = fields_ok && (dest_idx != crc32iu_pkg::ZeroReg);

  // An invalid instruction reports nothing but its own pc and its invalid status.
  always_comb begin
    out_status_d = !fields_ok;
    if (fields_ok) begin
      out_data_d = {2'b00, pc + 64'd4, dest_idx, wr_en, crc};
    end else begin
      out_data_d = {2'b00, pc, 5'd0, 1'b0, 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

`ifndef ASSERT_OFF
  a_invalid_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o[37:0] == 38'd0))
    else $error("invalid instruction carries a write or a result");

  a_write_not_zero_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[32]) |->
      (m_axis_tdata_o[37:33] != crc32iu_pkg::ZeroReg && !m_axis_tuser_o[0]))
    else $error("write enabled toward the zero register or on an invalid instruction");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("instruction left the input register without reaching the output");

  a_blocked_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_data_q) && $stable(in_user_q)))
    else $error("input register changed while the output was stalled");
`endif

endmodule

>>> tb/tb_crc32_instruction_unit.sv
// Self-checking testbench for the CRC32/CRC32C instruction unit: random and directed
// instructions on the input stream, results checked in order by a scoreboard class.
// Depends on crc32iu_pkg and the crc32_instruction_unit RTL.

module tb_crc32_instruction_unit;

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusInvalid = 1'b1;

  // Operation codes that the unit must reject.
  localparam logic [1:0] VarBadA = 2'd2;
  localparam logic [1:0] VarBadB = 2'd3;

  localparam int unsigned NumRandomInstrs = 1750;
  localparam int unsigned StallLimit      = 2000;
  localparam int unsigned DrainCycles     = 8;

  // Laid out so that the low 184 bits are the input tdata and the top 3 bits its tuser.
  typedef struct packed {
    logic [1:0]  variant;
    logic        two_source;
    logic [63:0] pc;
    logic [63:0] data_val;
    logic [31:0] acc_val;
    logic [4:0]  dest_idx;
    logic [4:0]  data_idx;
    logic [4:0]  acc_idx;
    logic        wide;
    logic [3:0]  res_bytes;
    logic [3:0]  op_bytes;
  } instr_t;

  // Low 104 bits are the output tdata, the top bit its tuser.
  typedef struct packed {
    logic        status;
    logic [1:0]  pad;
    logic [63:0] next_pc;
    logic [4:0]  write_idx;
    logic        write_en;
    logic [31:0] crc;
  } writeback_t;

  class crc_exec_scoreboard;
    writeback_t  expected_writebacks[$];
    int unsigned failures;
    int unsigned instrs_seen;
    int unsigned writebacks_seen;
    int unsigned invalid_seen;
    int unsigned discarded_seen;

    function logic [31:0] reflected_crc(logic [31:0] acc_in, logic [63:0] data,
                                        logic [3:0] nbytes, logic [31:0] poly);
      logic [31:0] acc;
      acc = acc_in;
      for (int b = 0; b < 8; b++) begin
        if (b < nbytes) begin
          acc ^= {24'd0, data[8*b +: 8]};
          for (int k = 0; k < 8; k++) begin
            acc = acc[0] ? ((acc >> 1) ^ poly) : (acc >> 1);
          end
        end
      end
      return acc;
    endfunction

    function writeback_t execute_instr(instr_t ins);
      writeback_t wb;
      logic       legal;
      logic [31:0] acc;
      logic [63:0] data;
      legal = ins.two_source
           && (ins.variant == crc32iu_pkg::VarCrc32 || ins.variant == crc32iu_pkg::VarCrc32c)
           && (ins.op_bytes == crc32iu_pkg::Size1 || ins.op_bytes == crc32iu_pkg::Size2 ||
               ins.op_bytes == crc32iu_pkg::Size4 || ins.op_bytes == crc32iu_pkg::Size8)
           && (ins.res_bytes == crc32iu_pkg::ResultBytes)
           && (ins.wide == (ins.op_bytes == crc32iu_pkg::Size8));
      wb = '0;
      if (!legal) begin
        wb.status  = StatusInvalid;
        wb.next_pc = ins.pc;
      end else begin
        acc  = (ins.acc_idx == crc32iu_pkg::ZeroReg) ? 32'd0 : ins.acc_val;
        data = (ins.data_idx == crc32iu_pkg::ZeroReg) ? 64'd0 : ins.data_val;
        wb.status    = StatusOk;
        wb.crc       = reflected_crc(acc, data, ins.op_bytes,
                                     (ins.variant == crc32iu_pkg::VarCrc32c) ?
                                     crc32iu_pkg::PolyCrc32c : crc32iu_pkg::PolyCrc32);
        wb.write_en  = (ins.dest_idx != crc32iu_pkg::ZeroReg);
        wb.write_idx = ins.dest_idx;
        wb.next_pc   = ins.pc + 64'd4;
      end
      return wb;
    endfunction

    function void note_instr(instr_t ins);
      writeback_t wb;
      wb = execute_instr(ins);
      expected_writebacks.push_back(wb);
      instrs_seen++;
      if (wb.status == StatusInvalid) invalid_seen++;
      else if (!wb.write_en) discarded_seen++;
    endfunction

    function void report(string field, logic [63:0] exp_val, logic [63:0] got_val);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_val, got_val);
      failures++;
    endfunction

    function void check_result(writeback_t got);
      writeback_t exp_wb;
      writebacks_seen++;
      if (expected_writebacks.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, got);
        failures++;
        return;
      end
      exp_wb = expected_writebacks.pop_front();
      if (got.status !== exp_wb.status)
        report("status", 64'(exp_wb.status), 64'(got.status));
      if (got.crc !== exp_wb.crc) report("crc_result", 64'(exp_wb.crc), 64'(got.crc));
      if (got.write_en !== exp_wb.write_en)
        report("write_enable", 64'(exp_wb.write_en), 64'(got.write_en));
      if (got.write_idx !== exp_wb.write_idx)
        report("write_index", 64'(exp_wb.write_idx), 64'(got.write_idx));
      if (got.next_pc !== exp_wb.next_pc) report("next_pc", exp_wb.next_pc, got.next_pc);
      if (got.pad !== 2'b00) report("tdata padding", 64'd0, 64'(got.pad));
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [183:0] s_axis_tdata_i;
  logic [2:0]   s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [103:0] m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;

  crc_exec_scoreboard sb;
  bit                 send_steady;

  crc32_instruction_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [3:0] legal_size();
    case ($urandom_range(0, 3))
      0: return crc32iu_pkg::Size1;
      1: return crc32iu_pkg::Size2;
      2: return crc32iu_pkg::Size4;
      default: return crc32iu_pkg::Size8;
    endcase
  endfunction

  function automatic logic [4:0] rand_index();
    return ($urandom_range(0, 7) == 0) ? crc32iu_pkg::ZeroReg : 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic instr_t legal_instr(logic [1:0] variant, logic [3:0] asize);
    instr_t ins;
    ins.two_source  = 1'b1;
    ins.variant     = variant;
    ins.op_bytes    = asize;
    ins.res_bytes   = crc32iu_pkg::ResultBytes;
    ins.wide        = (asize == crc32iu_pkg::Size8);
    ins.acc_idx     = 5'($urandom_range(0, 30));
    ins.data_idx    = 5'($urandom_range(0, 30));
    ins.dest_idx    = 5'($urandom_range(0, 30));
    ins.acc_val     = 32'(rand_operand());
    ins.data_val    = rand_operand();
    ins.pc          = rand64();
    return ins;
  endfunction

  function automatic instr_t random_instr();
    instr_t ins;
    ins = legal_instr(($urandom_range(0, 1) != 0) ? crc32iu_pkg::VarCrc32c :
                      crc32iu_pkg::VarCrc32, legal_size());
    ins.acc_idx  = rand_index();
    ins.data_idx = rand_index();
    ins.dest_idx = rand_index();
    // One in five instructions has its decode fields scrambled.
    if ($urandom_range(0, 4) == 0) begin
      ins.two_source  = 1'($urandom());
      ins.variant     = 2'($urandom());
      ins.op_bytes    = 4'($urandom());
      ins.res_bytes   = 4'($urandom());
      ins.wide        = 1'($urandom());
    end
    return ins;
  endfunction

  task automatic send_instr(input instr_t ins);
    repeat (send_steady ? 0 : idle_len()) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = ins[183:0];
    s_axis_tuser_i  = ins[186:184];
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_instr(ins);
  endtask

  task automatic run_directed();
    instr_t ins;
    ins = legal_instr(crc32iu_pkg::VarCrc32, crc32iu_pkg::Size1);
    ins.acc_val  = '0;
    ins.data_val = '0;
    send_instr(ins);
    for (int v = 0; v < 2; v++) begin
      for (int s = 0; s < 4; s++) begin
        ins = legal_instr((v != 0) ? crc32iu_pkg::VarCrc32c : crc32iu_pkg::VarCrc32,
                          4'(1 << s));
        ins.acc_val  = '1;
        ins.data_val = '1;
        send_instr(ins);
      end
    end
    // Zero register as accumulator source, data source and destination.
    ins = legal_instr(crc32iu_pkg::VarCrc32, crc32iu_pkg::Size8);
    ins.acc_val = '1;
    ins.acc_idx = crc32iu_pkg::ZeroReg;
    send_instr(ins);
    ins = legal_instr(crc32iu_pkg::VarCrc32c, crc32iu_pkg::Size8);
    ins.data_val = '1;
    ins.data_idx = crc32iu_pkg::ZeroReg;
    send_instr(ins);
    ins = legal_instr(crc32iu_pkg::VarCrc32c, crc32iu_pkg::Size4);
    ins.dest_idx = crc32iu_pkg::ZeroReg;
    send_instr(ins);
    ins = legal_instr(crc32iu_pkg::VarCrc32, crc32iu_pkg::Size2);
    ins.pc = 64'hffff_ffff_ffff_fffe;
    send_instr(ins);
    // Each decode check failing on its own.
    ins = legal_instr(crc32iu_pkg::VarCrc32, crc32iu_pkg::Size4);
    ins.two_source = 1'b0;
    send_instr(ins);
    ins = legal_instr(VarBadA, crc32iu_pkg::Size4);
    send_instr(ins);
    ins = legal_instr(VarBadB, crc32iu_pkg::Size8);
    ins.pc = '1;
    send_instr(ins);
    ins = legal_instr(crc32iu_pkg::VarCrc32, 4'd0);
    send_instr(ins);
    ins = legal_instr(crc32iu_pkg::VarCrc32c, 4'd3);
    send_instr(ins);
    ins = legal_instr(crc32iu_pkg::VarCrc32, '1);
    send_instr(ins);
    ins = legal_instr(crc32iu_pkg::VarCrc32, crc32iu_pkg::Size1);
    ins.res_bytes = 4'd0;
    send_instr(ins);
    ins = legal_instr(crc32iu_pkg::VarCrc32c, crc32iu_pkg::Size2);
    ins.res_bytes = crc32iu_pkg::Size8;
    send_instr(ins);
    ins = legal_instr(crc32iu_pkg::VarCrc32, crc32iu_pkg::Size8);
    ins.res_bytes = '1;
    send_instr(ins);
    ins = legal_instr(crc32iu_pkg::VarCrc32, crc32iu_pkg::Size4);
    ins.wide = 1'b1;
    send_instr(ins);
    ins = legal_instr(crc32iu_pkg::VarCrc32c, crc32iu_pkg::Size8);
    ins.wide = 1'b0;
    send_instr(ins);
  endtask

  // Result side: random backpressure with occasional stretches of constant ready.
  initial begin
    int unsigned stall;
    bit          steady;
    m_axis_tready_i = 1'b0;
    steady = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      stall = steady ? 0 : idle_len();
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
      end
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result({m_axis_tuser_o, m_axis_tdata_o});
    end
  end

  // Ends the run if neither side completes a transfer for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, StallLimit);
    $display("crc32_instruction_unit test failed");
    $finish;
  end

  initial begin
    sb = new();
    send_steady     = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    for (int n = 0; n < NumRandomInstrs; n++) begin
      if ($urandom_range(0, 99) == 0) send_steady = !send_steady;
      send_instr(random_instr());
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;

    while (sb.expected_writebacks.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Executed %0d instructions (%0d rejected by decode, %0d with discarded result).",
             sb.instrs_seen, sb.invalid_seen, sb.discarded_seen);
    $display("Checked %0d results with %0d field mismatches or stray transfers.",
             sb.writebacks_seen, sb.failures);
    if (sb.failures == 0 && sb.expected_writebacks.size() == 0) begin
      $display("crc32_instruction_unit test passed");
    end else begin
      $display("crc32_instruction_unit test failed");
    end
    $finish;
  end

endmodule
